// File: hw/rtl/bmf_pkg.sv
// shared constants and types of the box mean filter
package bmf_pkg;

    localparam int MAX_RADIUS = 11;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int CHANNELS   = 3;
    localparam int LINES      = 2 * MAX_RADIUS + 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SLOT_W     = $clog2(LINES);
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int SUM_W      = 18;
    localparam int DIV_W      = 10;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic               start;
        logic signed [13:0] idx;
        logic [12:0]        n;
        logic               slot_en;
    } t_fold_req;

    typedef struct packed {
        logic        done;
        logic [11:0] value;
    } t_fold_rsp;

    typedef struct packed {
        logic clear;
        logic acc;
        logic div_start;
    } t_lane_ctl;

endpackage

// File: hw/rtl/bmf_fold.sv
// reflect-101 index fold with optional reduction to a line store slot
module bmf_fold (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bmf_pkg::t_fold_req  i_req,
    output bmf_pkg::t_fold_rsp  o_rsp
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_RED  = 3'd1;
    localparam logic [2:0] F_FIX  = 3'd2;
    localparam logic [2:0] F_SLOT = 3'd3;
    localparam logic [2:0] F_DONE = 3'd4;

    logic [2:0]  r_state;
    logic [12:0] r_a;
    logic [12:0] r_n;
    logic [13:0] r_p;
    logic [3:0]  r_s;
    logic [11:0] r_m;
    logic        r_slot_en;

    logic [13:0] w_neg;
    logic [12:0] w_a;
    logic [13:0] w_p;
    logic [13:0] w_pa;
    logic [26:0] w_sh;
    logic [11:0] w_t;
    logic [13:0] w_fix;

    assign w_neg = -i_req.idx;
    assign w_a   = i_req.idx[13] ? w_neg[12:0] : i_req.idx[12:0];
    assign w_p   = {i_req.n - 13'd1, 1'b0};
    assign w_pa  = w_p - {1'b0, w_a};
    assign w_sh  = {13'd0, r_p} << r_s;
    assign w_t   = 12'(bmf_pkg::LINES) << r_s;
    assign w_fix = r_p - {1'b0, r_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_req.start) begin
                        r_n       <= i_req.n;
                        r_p       <= w_p;
                        r_a       <= w_a;
                        r_slot_en <= i_req.slot_en;
                        r_s       <= 4'd12;
                        if (i_req.n <= 13'd1) begin
                            r_m     <= 12'd0;
                            r_state <= F_DONE;
                        end else if (w_a < i_req.n) begin
                            r_m     <= w_a[11:0];
                            r_state <= (i_req.slot_en && w_a >= 13'(bmf_pkg::LINES))
                                       ? F_SLOT : F_DONE;
                            r_s     <= 4'd7;
                        end else if ({1'b0, w_a} < w_p) begin
                            r_m     <= w_pa[11:0];
                            r_state <= (i_req.slot_en && w_pa >= 14'(bmf_pkg::LINES))
                                       ? F_SLOT : F_DONE;
                            r_s     <= 4'd7;
                        end else begin
                            r_state <= F_RED;
                        end
                    end
                end
                F_RED: begin
                    if ({14'd0, r_a} >= w_sh) begin
                        r_a <= r_a - w_sh[12:0];
                    end
                    if (r_s == 4'd0) begin
                        r_state <= F_FIX;
                    end else begin
                        r_s <= r_s - 4'd1;
                    end
                end
                F_FIX: begin
                    r_s <= 4'd7;
                    if (r_a >= r_n) begin
                        r_m     <= w_fix[11:0];
                        r_state <= (r_slot_en && w_fix >= 14'(bmf_pkg::LINES))
                                   ? F_SLOT : F_DONE;
                    end else begin
                        r_m     <= r_a[11:0];
                        r_state <= (r_slot_en && r_a >= 13'(bmf_pkg::LINES))
                                   ? F_SLOT : F_DONE;
                    end
                end
                F_SLOT: begin
                    if (r_m >= w_t) begin
                        r_m <= r_m - w_t;
                    end
                    if (r_s == 4'd0) begin
                        r_state <= F_DONE;
                    end else begin
                        r_s <= r_s - 4'd1;
                    end
                end
                F_DONE: begin
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done  = (r_state == F_DONE);
    assign o_rsp.value = r_m;

endmodule

// File: hw/rtl/bmf_lane.sv
// one channel lane: window accumulator and restoring divider
module bmf_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bmf_pkg::t_lane_ctl                i_ctl,
    input  logic [7:0]                        i_sample,
    input  logic [bmf_pkg::DIV_W-1:0]         i_divisor,
    output logic [7:0]                        o_mean,
    output logic                              o_busy
);

    logic [bmf_pkg::SUM_W-1:0] r_sum;
    logic [bmf_pkg::SUM_W-1:0] r_q;
    logic [bmf_pkg::DIV_W:0]   r_rem;
    logic [bmf_pkg::DIV_W-1:0] r_d;
    logic [4:0]                r_cnt;
    logic                      r_busy;
    logic [bmf_pkg::DIV_W:0]   w_sh;

    assign w_sh = {r_rem[bmf_pkg::DIV_W-1:0], r_q[bmf_pkg::SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + {{(bmf_pkg::SUM_W-8){1'b0}}, i_sample};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.div_start) begin
            r_busy <= 1'b1;
            r_q    <= r_sum;
            r_rem  <= '0;
            r_d    <= i_divisor;
            r_cnt  <= 5'(bmf_pkg::SUM_W);
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_d}) begin
                r_rem <= w_sh - {1'b0, r_d};
                r_q   <= {r_q[bmf_pkg::SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[bmf_pkg::SUM_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_mean = r_q[7:0];
    assign o_busy = r_busy;

endmodule

// File: hw/rtl/bmf_out.sv
// merge of the lane results into the output register
module bmf_out (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_mean [bmf_pkg::CHANNELS],
    input  logic       i_frame_end,
    input  logic       i_stall,
    output logic       o_free,
    output logic       o_valid,
    output logic [7:0] o_mean_ch0,
    output logic [7:0] o_mean_ch1,
    output logic [7:0] o_mean_ch2,
    output logic       o_frame_end
);

    logic r_valid;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            o_mean_ch0  <= i_mean[0];
            o_mean_ch1  <= i_mean[1];
            o_mean_ch2  <= i_mean[2];
            o_frame_end <= i_frame_end;
        end
    end

    assign o_valid = r_valid;

endmodule

// File: hw/rtl/box_mean_filter_reflect_border_core.sv
// top level of the streaming box mean filter with reflect-101 border
// one item at a time: o_stall holds the next item off until the sequencer is idle again
// reset: synchronous active low, clears positions, frame count and handshakes,
//   and sets the config registers to their defaults
module box_mean_filter_reflect_border_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_pixel_ch0,
    input  logic [7:0]  i_pixel_ch1,
    input  logic [7:0]  i_pixel_ch2,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_mean_ch0,
    output logic [7:0]  o_mean_ch1,
    output logic [7:0]  o_mean_ch2,
    output logic        o_frame_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_ROWF  = 4'd2;
    localparam logic [3:0] S_ROWW  = 4'd3;
    localparam logic [3:0] S_COLF  = 4'd4;
    localparam logic [3:0] S_COLW  = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // configuration registers
    logic [3:0]  r_radius;
    logic [10:0] r_width;
    logic [12:0] r_height;

    // positions and frame bookkeeping
    logic [bmf_pkg::COL_W-1:0]  r_in_col;
    logic [bmf_pkg::ROW_W-1:0]  r_in_row;
    logic [bmf_pkg::SLOT_W-1:0] r_in_slot;
    logic [bmf_pkg::COL_W-1:0]  r_out_col;
    logic [bmf_pkg::ROW_W-1:0]  r_out_row;
    logic [7:0]                 r_frames_ahead;

    logic [3:0]                 r_state;
    logic signed [4:0]          r_dr;
    logic signed [4:0]          r_dc;
    logic [bmf_pkg::SLOT_W-1:0] r_row_slot;
    logic [23:0]                r_rd;

    // line store: LINES rows of MAX_WIDTH packed pixels
    logic [23:0] r_mem [bmf_pkg::LINES * bmf_pkg::MAX_WIDTH];

    // clamped working sizes
    logic [3:0]  w_r;
    logic [10:0] w_w;
    logic [12:0] w_h;
    logic [4:0]  w_span;
    logic [bmf_pkg::DIV_W-1:0] w_div;
    logic [12:0] w_need;
    logic [12:0] w_need_c;
    logic        w_ready;
    logic        w_last_col;
    logic        w_last_row;
    logic        w_in_acc;

    bmf_pkg::t_fold_req w_freq;
    bmf_pkg::t_fold_rsp w_frsp;
    bmf_pkg::t_lane_ctl w_lctl;

    logic [7:0]                    w_mean [bmf_pkg::CHANNELS];
    logic [bmf_pkg::CHANNELS-1:0]  w_busy;
    logic                          w_free;

    assign w_r = (r_radius == 4'd0) ? 4'd1
               : (r_radius > 4'(bmf_pkg::MAX_RADIUS)) ? 4'(bmf_pkg::MAX_RADIUS) : r_radius;
    assign w_w = (r_width == 11'd0) ? 11'd1
               : (r_width > 11'(bmf_pkg::MAX_WIDTH)) ? 11'(bmf_pkg::MAX_WIDTH) : r_width;
    assign w_h = (r_height == 13'd0) ? 13'd1
               : (r_height > 13'(bmf_pkg::MAX_HEIGHT)) ? 13'(bmf_pkg::MAX_HEIGHT) : r_height;

    // divisor is the window area (2r+1)^2
    assign w_span = {w_r, 1'b1};
    assign w_div  = bmf_pkg::DIV_W'(w_span) * bmf_pkg::DIV_W'(w_span);

    // result ready once the rows its window needs are in, or its whole frame is in
    assign w_need   = {1'b0, r_out_row} + {9'd0, w_r};
    assign w_need_c = (w_need > w_h - 13'd1) ? (w_h - 13'd1) : w_need;
    assign w_ready  = (r_frames_ahead != 8'd0) || ({1'b0, r_in_row} > w_need_c);

    assign w_last_col = ({1'b0, r_out_col} + 11'd1) >= w_w;
    assign w_last_row = ({1'b0, r_out_row} + 13'd1) >= w_h;

    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 4'd1;
            r_width  <= 11'd640;
            r_height <= 13'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmf_pkg::REG_RADIUS: r_radius <= i_cfg_data[3:0];
                bmf_pkg::REG_WIDTH:  r_width  <= i_cfg_data[10:0];
                bmf_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line store write and window read
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !i_action) begin
            r_mem[{r_in_slot, r_in_col}] <= {i_pixel_ch2, i_pixel_ch1, i_pixel_ch0};
        end
        if (r_state == S_COLW && w_frsp.done) begin
            r_rd <= r_mem[{r_row_slot, w_frsp.value[bmf_pkg::COL_W-1:0]}];
        end
    end

    // fold requests: rows reduce further to a store slot
    always_comb begin
        w_freq.start   = (r_state == S_ROWF) || (r_state == S_COLF);
        w_freq.slot_en = (r_state == S_ROWF);
        if (r_state == S_ROWF) begin
            w_freq.idx = $signed({2'b00, r_out_row}) + $signed({{9{r_dr[4]}}, r_dr});
            w_freq.n   = w_h;
        end else begin
            w_freq.idx = $signed({4'b0000, r_out_col}) + $signed({{9{r_dc[4]}}, r_dc});
            w_freq.n   = {2'b00, w_w};
        end
    end

    assign w_lctl.clear     = (r_state == S_CHECK);
    assign w_lctl.acc       = (r_state == S_ACC);
    assign w_lctl.div_start = (r_state == S_DIV);

    // sequencer and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_in_slot      <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_frames_ahead <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_CHECK;
                        if (!i_action) begin
                            if (({1'b0, r_in_col} + 11'd1) >= w_w) begin
                                r_in_col <= '0;
                                if (({1'b0, r_in_row} + 13'd1) >= w_h) begin
                                    r_in_row  <= '0;
                                    r_in_slot <= '0;
                                    if (r_frames_ahead != 8'hff) begin
                                        r_frames_ahead <= r_frames_ahead + 8'd1;
                                    end
                                end else begin
                                    r_in_row  <= r_in_row + 12'd1;
                                    r_in_slot <= (r_in_slot == bmf_pkg::SLOT_W'(bmf_pkg::LINES - 1))
                                                 ? '0 : r_in_slot + 5'd1;
                                end
                            end else begin
                                r_in_col <= r_in_col + 10'd1;
                            end
                        end
                    end
                end
                S_CHECK: begin
                    r_dr    <= -$signed({1'b0, w_r});
                    r_state <= w_ready ? S_ROWF : S_IDLE;
                end
                S_ROWF: r_state <= S_ROWW;
                S_ROWW: begin
                    if (w_frsp.done) begin
                        r_row_slot <= w_frsp.value[bmf_pkg::SLOT_W-1:0];
                        r_dc       <= -$signed({1'b0, w_r});
                        r_state    <= S_COLF;
                    end
                end
                S_COLF: r_state <= S_COLW;
                S_COLW: begin
                    if (w_frsp.done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    // walk the window column by column inside each row
                    if (r_dc == $signed({1'b0, w_r})) begin
                        if (r_dr == $signed({1'b0, w_r})) begin
                            r_state <= S_DIV;
                        end else begin
                            r_dr    <= r_dr + 5'sd1;
                            r_state <= S_ROWF;
                        end
                    end else begin
                        r_dc    <= r_dc + 5'sd1;
                        r_state <= S_COLF;
                    end
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_busy == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                        if (w_last_col) begin
                            r_out_col <= '0;
                            if (w_last_row) begin
                                r_out_row <= '0;
                                if (r_frames_ahead != 8'd0) begin
                                    r_frames_ahead <= r_frames_ahead - 8'd1;
                                end
                            end else begin
                                r_out_row <= r_out_row + 12'd1;
                            end
                        end else begin
                            r_out_col <= r_out_col + 10'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    bmf_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_freq),
        .o_rsp   (w_frsp)
    );

    // one lane per color channel
    for (genvar g = 0; g < bmf_pkg::CHANNELS; g++) begin : g_lane
        bmf_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_lctl),
            .i_sample  (r_rd[8*g +: 8]),
            .i_divisor (w_div),
            .o_mean    (w_mean[g]),
            .o_busy    (w_busy[g])
        );
    end

    bmf_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_state == S_OUT),
        .i_mean      (w_mean),
        .i_frame_end (w_last_col && w_last_row),
        .i_stall     (i_stall),
        .o_free      (w_free),
        .o_valid     (o_valid),
        .o_mean_ch0  (o_mean_ch0),
        .o_mean_ch1  (o_mean_ch1),
        .o_mean_ch2  (o_mean_ch2),
        .o_frame_end (o_frame_end)
    );

    // an accepted item always moves on to the ready check
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_CHECK))
        else $error("accepted item did not reach ready check");

    // dividers are quiet whenever the block waits for input
    a_lanes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_busy == '0))
        else $error("lane divider busy while idle");

    // the fold unit only answers while the sequencer waits for it
    a_fold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frsp.done |-> (r_state == S_ROWW || r_state == S_COLW))
        else $error("fold result outside a wait state");

    // output count drops only when a frame's last result leaves
    a_frames_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frames_ahead < $past(r_frames_ahead)) |-> ($past(r_state) == S_OUT))
        else $error("frame count dropped without a result");

endmodule

// File: dv/tb.sv
// testbench of the box mean filter: random frames checked against a window-mean predictor
`timescale 1ns / 1ps

module tb;

    // item kinds on the input channel
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam int ROWS_KEPT   = 2 * bmf_pkg::MAX_RADIUS + 2;
    localparam int CYCLE_LIMIT = 6000000;
    // margin after the last result before a register write
    localparam int SETTLE_CYCLES = 4000;

    typedef struct packed {
        logic [7:0] mean0;
        logic [7:0] mean1;
        logic [7:0] mean2;
        logic       frame_end;
    } mean_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = ACT_PIXEL;
    logic [7:0]  i_pixel_ch0 = '0;
    logic [7:0]  i_pixel_ch1 = '0;
    logic [7:0]  i_pixel_ch2 = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_mean_ch0;
    logic [7:0]  o_mean_ch1;
    logic [7:0]  o_mean_ch2;
    logic        o_frame_end;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = bmf_pkg::REG_RADIUS;
    logic [12:0] i_cfg_data = '0;

    box_mean_filter_reflect_border_core uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state: register copies, line store, positions
    logic [3:0]  radius_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] line_store [ROWS_KEPT * bmf_pkg::MAX_WIDTH];
    int unsigned in_row, in_col, out_row, out_col, frames_ahead;

    mean_t expected_means [$];
    int    errors = 0;
    int    items_sent = 0;
    int    means_seen = 0;
    int    frames_done = 0;
    bit    quiet = 1'b0;
    int    cycles = 0;

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // reflect-101 index fold into 0..n-1
    function automatic int reflect(int idx, int n);
        int p;
        int m;
        if (n <= 1) return 0;
        p = 2 * (n - 1);
        m = ((idx % p) + p) % p;
        if (m >= n) m = p - m;
        return m;
    endfunction

    task automatic predict_mean(logic act, logic [7:0] p0, logic [7:0] p1, logic [7:0] p2);
        int unsigned r, w, h, need, div;
        int unsigned sum0, sum1, sum2;
        int          rr, cc;
        logic [23:0] px;
        mean_t       m;
        r = clamp(radius_reg, 1, bmf_pkg::MAX_RADIUS);
        w = clamp(width_reg, 1, bmf_pkg::MAX_WIDTH);
        h = clamp(height_reg, 1, bmf_pkg::MAX_HEIGHT);
        if (act == ACT_PIXEL) begin
            line_store[(in_row % ROWS_KEPT) * bmf_pkg::MAX_WIDTH +
                       (in_col < bmf_pkg::MAX_WIDTH ? in_col : bmf_pkg::MAX_WIDTH - 1)] =
                {p2, p1, p0};
            if (in_col + 1 >= w) begin
                in_col = 0;
                if (in_row + 1 >= h) begin
                    in_row = 0;
                    if (frames_ahead < 255) frames_ahead++;
                end else begin
                    in_row++;
                end
            end else begin
                in_col++;
            end
        end
        need = out_row + r;
        if (need > h - 1) need = h - 1;
        if (frames_ahead == 0 && in_row <= need) return;
        sum0 = 0;
        sum1 = 0;
        sum2 = 0;
        for (int dc = -int'(r); dc <= int'(r); dc++) begin
            cc = reflect(int'(out_col) + dc, int'(w));
            for (int dr = -int'(r); dr <= int'(r); dr++) begin
                rr = reflect(int'(out_row) + dr, int'(h));
                px = line_store[(rr % ROWS_KEPT) * bmf_pkg::MAX_WIDTH + cc];
                sum0 += px[7:0];
                sum1 += px[15:8];
                sum2 += px[23:16];
            end
        end
        div = (2 * r + 1) * (2 * r + 1);
        m.mean0 = 8'(sum0 / div);
        m.mean1 = 8'(sum1 / div);
        m.mean2 = 8'(sum2 / div);
        m.frame_end = 1'b0;
        if (out_col + 1 >= w) begin
            out_col = 0;
            if (out_row + 1 >= h) begin
                out_row = 0;
                m.frame_end = 1'b1;
                if (frames_ahead > 0) frames_ahead--;
            end else begin
                out_row++;
            end
        end else begin
            out_col++;
        end
        expected_means.push_back(m);
    endtask

    // one item through the handshake, sometimes with a random gap first
    task automatic send_item(logic act, logic [7:0] p0, logic [7:0] p1, logic [7:0] p2);
        if (!quiet && $urandom_range(0, 11) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_pixel_ch0 <= p0;
        i_pixel_ch1 <= p1;
        i_pixel_ch2 <= p2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_mean(act, p0, p1, p2);
        items_sent++;
    endtask

    task automatic send_pixel();
        send_item(ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // drain ticks until every frame sent has been output
    task automatic drain_frames();
        while (frames_ahead != 0) send_item(ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        i_valid <= 1'b0;
    endtask

    // block must be idle before a register write
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bmf_pkg::REG_RADIUS: radius_reg = data[3:0];
            bmf_pkg::REG_WIDTH:  width_reg  = data[10:0];
            bmf_pkg::REG_HEIGHT: height_reg = data[12:0];
            default: ;
        endcase
    endtask

    task automatic set_shape(int r, int w, int h);
        write_reg(bmf_pkg::REG_RADIUS, 13'(r));
        write_reg(bmf_pkg::REG_WIDTH, 13'(w));
        write_reg(bmf_pkg::REG_HEIGHT, 13'(h));
    endtask

    task automatic send_frames(int n);
        int w, h;
        w = clamp(width_reg, 1, bmf_pkg::MAX_WIDTH);
        h = clamp(height_reg, 1, bmf_pkg::MAX_HEIGHT);
        repeat (n * w * h) begin
            // stray drain ticks inside a frame
            if ($urandom_range(0, 24) == 0) send_item(ACT_DRAIN, 8'hff, 8'h00, 8'hff);
            send_pixel();
        end
    endtask

    // one-pixel and tiny images: in the 1x1 image each pixel closes a frame, windows fold deeply
    task automatic test_tiny_images();
        set_shape(0, 0, 1);
        send_item(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(ACT_PIXEL, 8'hff, 8'hff, 8'hff);
        send_item(ACT_PIXEL, 8'h55, 8'haa, 8'h0f);
        send_item(ACT_DRAIN, 8'hff, 8'hff, 8'hff);  // nothing ready, no result
        send_item(ACT_PIXEL, 8'h80, 8'h01, 8'hfe);
        wait_idle();
        set_shape(15, 2, 3);
        send_item(ACT_PIXEL, 8'hff, 8'h00, 8'h7f);
        send_item(ACT_PIXEL, 8'h00, 8'hff, 8'h80);
        send_item(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        repeat (4) send_pixel();
        drain_frames();
        wait_idle();
    endtask

    // every config data bit high, then the largest radius on a 12 by 12 image
    task automatic test_large_radius();
        write_reg(bmf_pkg::REG_RADIUS, 13'h1fff);
        write_reg(bmf_pkg::REG_WIDTH, 13'h1fff);
        write_reg(bmf_pkg::REG_HEIGHT, 13'h1fff);
        set_shape(11, 12, 12);
        send_frames(1);
        drain_frames();
        wait_idle();
    endtask

    // sender holds off mid frame until all results are in
    task automatic test_stream_pause();
        set_shape(1, 12, 12);
        repeat (60) send_pixel();
        i_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (84) send_pixel();
        drain_frames();
        wait_idle();
    endtask

    // back-to-back frames with random shapes and pixels
    task automatic test_random_frames();
        int r, w, h, n;
        while (items_sent < 1050) begin
            if (items_sent > 850) quiet = 1'b1;
            r = $urandom_range(1, 3);
            w = $urandom_range(12, 20);
            h = $urandom_range(12, 16);
            n = $urandom_range(1, 2);
            // keep the item count near its target at the end
            if (n * w * h > 1050 - items_sent) begin
                n = 1;
                w = 12;
                h = 12;
            end
            set_shape(r, w, h);
            send_frames(n);
            drain_frames();
            wait_idle();
        end
    endtask

    // checker and receiver stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            mean_t want;
            means_seen++;
            if (expected_means.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                want = expected_means.pop_front();
                if (o_mean_ch0 !== want.mean0) begin
                    $error("mean_ch0 expected %0d got %0d", want.mean0, o_mean_ch0);
                    errors++;
                end
                if (o_mean_ch1 !== want.mean1) begin
                    $error("mean_ch1 expected %0d got %0d", want.mean1, o_mean_ch1);
                    errors++;
                end
                if (o_mean_ch2 !== want.mean2) begin
                    $error("mean_ch2 expected %0d got %0d", want.mean2, o_mean_ch2);
                    errors++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end expected %0d got %0d", want.frame_end, o_frame_end);
                    errors++;
                end
                if (want.frame_end) frames_done++;
            end
        end
        if (quiet) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        radius_reg   = 4'd1;
        width_reg    = 11'd640;
        height_reg   = 13'd480;
        in_row       = 0;
        in_col       = 0;
        out_row      = 0;
        out_col      = 0;
        frames_ahead = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tiny_images();
        test_large_radius();
        test_stream_pause();
        test_random_frames();
        $display("covered %0d items, %0d window means, %0d frames", items_sent, means_seen,
                 frames_done);
        $display("tiny and folded images, radius 1 to 11, stalls, gaps and a mid-frame pause");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
